/* hdl/packet_log_aggregation_table_macros.svh */
// Assertion helpers for the aggregation table; clk and arst_n come from the using module.
`ifndef PACKET_LOG_AGGREGATION_TABLE_MACROS_SVH
`define PACKET_LOG_AGGREGATION_TABLE_MACROS_SVH

// Same-cycle implication.
`define PLAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PLAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/plat_pkg.sv */
`default_nettype none

package plat_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam int unsigned POS_W = 6;
	localparam int unsigned TOTAL_W = 7;

	typedef enum logic [1:0] {
		OP_LOG    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NEW    = 3'd0,
		ST_HIT    = 3'd1,
		ST_MISS   = 3'd2,
		ST_FULL   = 3'd3,
		ST_BADPOS = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  protocol;
		logic        verdict;
		logic [2:0]  hook;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] reason;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] hits;
		logic [31:0] stamp;
	} rec_t;

	typedef struct packed {
		op_t                operation;
		logic [7:0]         protocol;
		logic               verdict;
		logic [2:0]         hook;
		logic [31:0]        source_address;
		logic [31:0]        dest_address;
		logic [15:0]        source_port;
		logic [15:0]        dest_port;
		logic signed [31:0] reason_code;
		logic [31:0]        time_seconds;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [31:0]        hit_count;
		logic [31:0]        last_seen;
		logic [TOTAL_W-1:0] record_total;
		logic [7:0]         out_protocol;
		logic               out_verdict;
		logic [2:0]         out_hook;
		logic [31:0]        out_source_address;
		logic [31:0]        out_dest_address;
		logic [15:0]        out_source_port;
		logic [15:0]        out_dest_port;
		logic signed [31:0] out_reason;
	} rsp_t;

	function automatic key_t key_of(req_t r);
		key_t k;
		k.protocol       = r.protocol;
		k.verdict        = r.verdict;
		k.hook           = r.hook;
		k.source_address = r.source_address;
		k.dest_address   = r.dest_address;
		k.source_port    = r.source_port;
		k.dest_port      = r.dest_port;
		k.reason         = $unsigned(r.reason_code);
		return k;
	endfunction

endpackage

`default_nettype wire

/* hdl/plat_req_if.sv */
`default_nettype none

interface plat_req_if;
	import plat_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/plat_rsp_if.sv */
`default_nettype none

interface plat_rsp_if;
	import plat_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/packet_log_aggregation_table.sv */
// Ordered table of packet log records in one RAM, searched in insertion order by a
// single read port and one key comparator. Each item is processed alone: ready is
// high only between items. Log and remove scan one record per cycle; a remove that
// hits then moves the n-p-1 later records of a table of n records down one place
// (hit at position p). A read passes through a read state on its way to done; clear
// and a read of an invalid position go straight to done. The result waits in an
// output register; the next item is accepted as soon as the sequencer is back in
// idle, even if that result is not yet taken, and the sequencer holds its own result
// until the register is free.
`default_nettype none
`include "packet_log_aggregation_table_macros.svh"

module packet_log_aggregation_table #(
	parameter int unsigned TABLE_ENTRIES = plat_pkg::TABLE_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	plat_req_if.sink   req,
	plat_rsp_if.source rsp
);
	import plat_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_READ  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] walk_q;
	logic             walk_vld_s1;
	logic [CNT_W-1:0] walk_idx_s1;
	req_t             in_q;
	rec_t             hold_q;
	status_t          status_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	rec_t             wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	rec_t             rd_data;

	logic accept;
	logic walk_issue;
	logic match;
	logic scan_miss;
	logic table_full;
	logic pos_ok;
	rec_t hit_rec;
	rec_t new_rec;

	plat_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign walk_issue = (walk_q < count_q);
	assign match      = walk_vld_s1 && (rd_data.key == key_of(in_q));
	assign scan_miss  = !walk_vld_s1 && !walk_issue;
	assign table_full = (count_q >= CNT_W'(TABLE_ENTRIES));
	assign pos_ok     = (CMP_W'(req.payload.position) < CMP_W'(count_q));

	always_comb begin
		hit_rec       = rd_data;
		hit_rec.hits  = (rd_data.hits == '1) ? rd_data.hits : rd_data.hits + 32'd1;
		hit_rec.stamp = in_q.time_seconds;
		new_rec.key   = key_of(in_q);
		new_rec.hits  = 32'd1;
		new_rec.stamp = in_q.time_seconds;
	end

	// RAM port steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = walk_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = walk_idx_s1[IDX_W-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.payload.operation == OP_READ) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(req.payload.position);
				end
			end
			S_SCAN: begin
				rd_en = walk_issue;
				if (match && in_q.operation == OP_LOG) begin
					wr_en   = 1'b1;
					wr_data = hit_rec;
				end else if (scan_miss && in_q.operation == OP_LOG && !table_full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[IDX_W-1:0];
					wr_data = new_rec;
				end
			end
			S_SHIFT: begin
				rd_en = walk_issue;
				if (walk_vld_s1) begin
					// move the record just read down one place
					wr_en   = 1'b1;
					wr_addr = IDX_W'(walk_idx_s1 - 1'b1);
				end
			end
			S_READ, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			walk_q      <= '0;
			walk_vld_s1 <= 1'b0;
			walk_idx_s1 <= '0;
			in_q        <= '0;
			hold_q      <= '0;
			status_q    <= ST_HIT;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in S_DONE a result taken now is replaced by the next one
			if (rsp.valid && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_q        <= req.payload;
						walk_q      <= '0;
						walk_vld_s1 <= 1'b0;
						hold_q      <= '0;
						unique case (req.payload.operation)
							OP_LOG, OP_REMOVE: begin
								state_q <= S_SCAN;
							end
							OP_CLEAR: begin
								count_q  <= '0;
								status_q <= ST_HIT;
								state_q  <= S_DONE;
							end
							OP_READ: begin
								if (pos_ok) begin
									state_q <= S_READ;
								end else begin
									status_q <= ST_BADPOS;
									state_q  <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					hold_q   <= rd_data;
					status_q <= ST_HIT;
					state_q  <= S_DONE;
				end
				S_SCAN: begin
					walk_idx_s1 <= walk_q;
					if (match && in_q.operation != OP_LOG) begin
						// close the gap from the record after the hit
						status_q    <= ST_HIT;
						hold_q      <= rd_data;
						walk_q      <= CNT_W'(walk_idx_s1 + 1'b1);
						walk_vld_s1 <= 1'b0;
						state_q     <= S_SHIFT;
					end else begin
						walk_vld_s1 <= walk_issue;
						if (walk_issue) begin
							walk_q <= CNT_W'(walk_q + 1'b1);
						end
						if (match) begin
							status_q <= ST_HIT;
							hold_q   <= hit_rec;
							state_q  <= S_DONE;
						end else if (scan_miss) begin
							state_q <= S_DONE;
							if (in_q.operation != OP_LOG) begin
								status_q <= ST_MISS;
							end else if (table_full) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_NEW;
								hold_q   <= new_rec;
								count_q  <= CNT_W'(count_q + 1'b1);
							end
						end
					end
				end
				S_SHIFT: begin
					walk_vld_s1 <= walk_issue;
					walk_idx_s1 <= walk_q;
					if (walk_issue) begin
						walk_q <= CNT_W'(walk_q + 1'b1);
					end else if (!walk_vld_s1) begin
						count_q <= CNT_W'(count_q - 1'b1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q.status             <= status_q;
						rsp_q.hit_count          <= hold_q.hits;
						rsp_q.last_seen          <= hold_q.stamp;
						rsp_q.record_total       <= TOTAL_W'(count_q);
						rsp_q.out_protocol       <= hold_q.key.protocol;
						rsp_q.out_verdict        <= hold_q.key.verdict;
						rsp_q.out_hook           <= hold_q.key.hook;
						rsp_q.out_source_address <= hold_q.key.source_address;
						rsp_q.out_dest_address   <= hold_q.key.dest_address;
						rsp_q.out_source_port    <= hold_q.key.source_port;
						rsp_q.out_dest_port      <= hold_q.key.dest_port;
						rsp_q.out_reason         <= $signed(hold_q.key.reason);
						rsp_valid_q              <= 1'b1;
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PLAT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_ENTRIES), "record count over capacity")
	`PLAT_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready, "item accepted while busy")
	`PLAT_ASSERT_NOW(a_shift_in_range, state_q == S_SHIFT && wr_en, walk_idx_s1 < count_q, "compaction write past table end")
	`PLAT_ASSERT_NEXT(a_done_waits, state_q == S_DONE && rsp_valid_q && !rsp.ready, state_q == S_DONE, "result overwrote a pending item")
	`PLAT_ASSERT_NOW(a_append_not_full, state_q == S_SCAN && wr_en && !match, !table_full, "append into full table")
endmodule

`default_nettype wire

/* hdl/plat_ram.sv */
`default_nettype none

module plat_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

`default_nettype wire
